@@ hdl/csr_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle span rasterizer package
// Shared constants and the stage record passed down the span pipeline.
// ----------------------------------------------------------------------------
package csr_pkg;

  localparam int ScreenWidth  = 240;
  localparam int ScreenHeight = 240;
  localparam int MaxRadius    = 31;

  localparam int CoordW = 10;
  localparam int RadW   = 5;
  localparam int ColorW = 16;
  localparam int RowW   = 8;
  localparam int LenW   = 6;
  localparam int SqW    = 10;
  localparam int RootW  = 5;
  localparam int WideW  = 13;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [RadW+1:0]   dy;
    logic [ColorW-1:0]        color;
    logic                     last;
  } span_ctx_t;

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [RowW-1:0]   start;
    logic [LenW-1:0]   length;
    logic [ColorW-1:0] color;
    logic              vis;
    logic              last;
  } span_out_t;

endpackage

@@ hdl/csr_span_pipe.sv @@
// ----------------------------------------------------------------------------
// Span pipeline
// Square, integer square root in five stages, then clipping, with stall.
// ----------------------------------------------------------------------------
module csr_span_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csr_pkg::span_ctx_t   in_ctx,
  input  logic [csr_pkg::RadW-1:0] in_r,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csr_pkg::span_out_t   out_span
);

  localparam int NS = 8;

  logic                          vld [NS];
  csr_pkg::span_ctx_t            ctx [NS-1];
  logic [csr_pkg::SqW-1:0]       rem [NS-2];
  logic [csr_pkg::RootW-1:0]     root [NS-1];
  logic                          adv;
  logic [csr_pkg::SqW-1:0]       sq_next;
  logic [csr_pkg::RadW:0]        ady;
  csr_pkg::span_out_t            res_next;
  logic signed [csr_pkg::WideW-1:0] row_w, first_w, end_w;

  assign adv = !vld[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NS-1];

  always_comb begin
    ady = in_ctx.dy[csr_pkg::RadW+1] ? (csr_pkg::RadW+1)'(-in_ctx.dy)
                                     : (csr_pkg::RadW+1)'(in_ctx.dy);
    sq_next = csr_pkg::SqW'(in_r * in_r) - csr_pkg::SqW'(ady * ady);
  end

  always_comb begin
    row_w   = csr_pkg::WideW'(ctx[NS-2].cy) + csr_pkg::WideW'(ctx[NS-2].dy);
    first_w = csr_pkg::WideW'(ctx[NS-2].cx) - csr_pkg::WideW'({1'b0, root[NS-2]});
    end_w   = csr_pkg::WideW'(ctx[NS-2].cx) + csr_pkg::WideW'({1'b0, root[NS-2]}) + 13'sd1;
    if (first_w < 0) first_w = '0;
    if (end_w > csr_pkg::WideW'(csr_pkg::ScreenWidth))
      end_w = csr_pkg::WideW'(csr_pkg::ScreenWidth);
    res_next.vis = !(row_w < 0 || row_w >= csr_pkg::WideW'(csr_pkg::ScreenHeight)
                     || end_w <= first_w);
    res_next.row    = res_next.vis ? row_w[csr_pkg::RowW-1:0] : '0;
    res_next.start  = res_next.vis ? first_w[csr_pkg::RowW-1:0] : '0;
    res_next.length = res_next.vis ? csr_pkg::LenW'(end_w - first_w) : '0;
    res_next.color  = ctx[NS-2].color;
    res_next.last   = ctx[NS-2].last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0]  <= in_ctx;
      rem[0]  <= sq_next;
      root[0] <= '0;
      for (int i = 1; i <= csr_pkg::RootW; i++) begin
        logic [csr_pkg::RootW-1:0] t;
        t = root[i-1] | csr_pkg::RootW'(1 << (csr_pkg::RootW - i));
        ctx[i]  <= ctx[i-1];
        if (i < NS - 2) rem[i] <= rem[i-1];
        root[i] <= (csr_pkg::SqW'(t * t) <= rem[i-1]) ? t : root[i-1];
      end
      ctx[NS-2]  <= ctx[NS-3];
      root[NS-2] <= root[NS-3];
      out_span   <= res_next;
    end
  end

endmodule

@@ hdl/circle_span_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// Circle span rasterizer
// Turns one filled-circle command into 2*radius+1 clipped horizontal spans.
// ----------------------------------------------------------------------------
// Each span passes the square, square-root and clipping registers of the span
// pipeline. The issuer sends one span per cycle when the pipeline does not
// stall, and takes a new command once the previous one's last span is issued.
// The span pipeline accepts one row offset per cycle when not stalled.
// Reset clears the issuer, the held command and all pipeline valid bits.
module circle_span_rasterizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [9:0] center_x,
  input  logic signed [9:0] center_y,
  input  logic [4:0]  radius,
  input  logic [15:0] fill_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  span_row,
  output logic [7:0]  span_start,
  output logic [5:0]  span_length,
  output logic [15:0] span_color,
  output logic        visible,
  output logic        last_span
);

  logic                busy;
  logic signed [9:0]   held_cx, held_cy;
  logic [4:0]          held_r;
  logic [15:0]         held_color;
  logic signed [6:0]   dy;
  logic                p_ready;
  csr_pkg::span_ctx_t  ctx;
  csr_pkg::span_out_t  span;

  assign in_ready = !busy;
  assign ctx.cx = held_cx;
  assign ctx.cy = held_cy;
  assign ctx.dy = dy;
  assign ctx.color = held_color;
  assign ctx.last = (dy == $signed({2'b00, held_r}));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && !busy) begin
      busy <= 1'b1;
    end else if (busy && p_ready && ctx.last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cx    <= '0;
      held_cy    <= '0;
      held_r     <= '0;
      held_color <= '0;
      dy         <= '0;
    end else if (in_valid && !busy) begin
      held_cx    <= center_x;
      held_cy    <= center_y;
      held_r     <= radius;
      held_color <= fill_color;
      dy         <= -$signed({2'b00, radius});
    end else if (busy && p_ready) begin
      dy <= dy + 7'sd1;
    end
  end

  csr_span_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (busy),
    .in_ready (p_ready),
    .in_ctx   (ctx),
    .in_r     (held_r),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_span (span)
  );

  assign span_row    = span.row;
  assign span_start  = span.start;
  assign span_length = span.length;
  assign span_color  = span.color;
  assign visible     = span.vis;
  assign last_span   = span.last;

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> span_length == 6'd0) else $error("length on hidden span");
  a_len_vis: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> span_length != 6'd0) else $error("empty visible span");
  a_busy_dy: assert property (@(posedge clk) disable iff (rst)
    busy |-> dy <= $signed({2'b00, held_r})) else $error("row offset overrun");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Circle span rasterizer testbench
// Sends filled-circle commands with random idling on both sides, predicts the
// clipped spans of each accepted command, and compares every span in order.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic signed [9:0] cx;
    logic signed [9:0] cy;
    logic [4:0]        rad;
    logic [15:0]       color;
  } circle_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [9:0] center_x = '0;
  logic signed [9:0] center_y = '0;
  logic [4:0] radius = '0;
  logic [15:0] fill_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] span_row;
  logic [7:0] span_start;
  logic [5:0] span_length;
  logic [15:0] span_color;
  logic visible;
  logic last_span;

  circle_cmd_t pending_cmds[$];
  csr_pkg::span_out_t expected_spans[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  bit drain_pause = 1'b0;
  bit stim_done = 1'b0;

  circle_span_rasterizer_top dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int isqrt(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  task automatic predict_spans(circle_cmd_t c);
    int r, dx, row, first, stop;
    csr_pkg::span_out_t s;
    r = c.rad;
    if (r > csr_pkg::MaxRadius) r = csr_pkg::MaxRadius;
    for (int dy = -r; dy <= r; dy++) begin
      dx = isqrt(r * r - dy * dy);
      row = c.cy + dy;
      first = c.cx - dx;
      stop = first + 2 * dx + 1;
      if (first < 0) first = 0;
      if (stop > csr_pkg::ScreenWidth) stop = csr_pkg::ScreenWidth;
      s = '0;
      s.vis = !(row < 0 || row >= csr_pkg::ScreenHeight || stop <= first);
      if (s.vis) begin
        s.row = row[7:0];
        s.start = first[7:0];
        s.length = 6'(stop - first);
      end
      s.color = c.color;
      s.last = (dy == r);
      expected_spans.push_back(s);
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_spans({center_x, center_y, radius, fill_color});
      if (!(in_valid && !in_ready)) begin
        if (in_valid && in_ready && send_gap == 0 && pending_cmds.size() > 0 && !drain_pause)
        begin
          {center_x, center_y, radius, fill_color} <= pending_cmds.pop_front();
          send_gap <= $urandom_range(0, 16) * ($urandom_range(0, 3) == 0);
        end else if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (drain_pause && expected_spans.size() > 0) begin
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          {center_x, center_y, radius, fill_color} <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          send_gap <= $urandom_range(0, 16) * ($urandom_range(0, 3) == 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    csr_pkg::span_out_t s;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          report("unexpected span row", span_row, -1);
        end else begin
          s = expected_spans.pop_front();
          if (span_row !== s.row) report("span_row", span_row, s.row);
          if (span_start !== s.start) report("span_start", span_start, s.start);
          if (span_length !== s.length) report("span_length", span_length, s.length);
          if (span_color !== s.color) report("span_color", span_color, s.color);
          if (visible !== s.vis) report("visible", visible, s.vis);
          if (last_span !== s.last) report("last_span", last_span, s.last);
        end
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (out_valid && out_ready || !out_ready) begin
        out_ready <= 1'b1;
        recv_gap <= $urandom_range(0, 16) * ($urandom_range(0, 3) == 0);
      end
    end
  end

  function automatic circle_cmd_t rand_cmd();
    circle_cmd_t c;
    c.color = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      c.cx = 10'($urandom);
      c.cy = 10'($urandom);
    end else begin
      c.cx = 10'($urandom_range(0, 300)) - 10'sd30;
      c.cy = 10'($urandom_range(0, 300)) - 10'sd30;
    end
    c.rad = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 8));
    return c;
  endfunction

  initial begin
    pending_cmds.push_back('{10'sd120, 10'sd120, 5'd0, 16'h0000});
    pending_cmds.push_back('{10'sd120, 10'sd120, 5'd31, 16'hFFFF});
    pending_cmds.push_back('{-10'sd512, -10'sd512, 5'd31, 16'hA5A5});
    pending_cmds.push_back('{10'sd511, 10'sd511, 5'd31, 16'h5A5A});
    pending_cmds.push_back('{10'sd0, 10'sd0, 5'd10, 16'h1234});
    pending_cmds.push_back('{10'sd239, 10'sd239, 5'd10, 16'h8001});
    pending_cmds.push_back('{-10'sd10, 10'sd100, 5'd10, 16'h0F0F});
    pending_cmds.push_back('{-10'sd11, 10'sd100, 5'd10, 16'hF0F0});
    pending_cmds.push_back('{10'sd250, 10'sd100, 5'd10, 16'h00FF});
    pending_cmds.push_back('{10'sd249, 10'sd100, 5'd10, 16'hFF00});
    pending_cmds.push_back('{10'sd100, -10'sd5, 5'd6, 16'h7777});
    pending_cmds.push_back('{10'sd100, 10'sd236, 5'd6, 16'h3333});
    pending_cmds.push_back('{10'sd5, 10'sd5, 5'd31, 16'hCCCC});
    pending_cmds.push_back('{10'sd230, 10'sd230, 5'd31, 16'h2468});
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 100; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    hold_off <= 2000;
    for (int i = 0; i < 60; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    drain_pause <= 1'b1;
    wait (expected_spans.size() == 0 && !(in_valid && !in_ready) && !in_valid);
    @(posedge clk);
    drain_pause <= 1'b0;
    for (int i = 0; i < 140; i++) pending_cmds.push_back(rand_cmd());
    wait (pending_cmds.size() == 0 && !in_valid);
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (stim_done && expected_spans.size() == 0) begin
      stim_done = 1'b0;
      repeat (40) @(posedge clk);
      if (errors == 0 && expected_spans.size() == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
      $finish;
    end
  end
endmodule

@@ circle_span_rasterizer_top.f @@
hdl/csr_pkg.sv
hdl/csr_span_pipe.sv
hdl/circle_span_rasterizer_top.sv
tb/sv/tb.sv
